// ===== rtl/core/sexe_pkg.sv =====
// Shared types, constants and helpers for the single-executor election block.
// No dependencies; imported by sexe_core and single_executor_election_top.
`default_nettype none

package sexe_pkg;

	localparam int unsigned MAX_THREADS = 16;
	localparam int unsigned MAX_TAGS    = 16;

	localparam int unsigned TID_W  = 4;   // thread id width
	localparam int unsigned SLOT_W = 4;   // tag slot / ring position width
	localparam int unsigned CNT_W  = 4;   // arrival counter width
	localparam int unsigned REG_W  = 5;   // config register width

	// config register indexes
	localparam logic REG_THREAD_COUNT = 1'b0;
	localparam logic REG_TAG_COUNT    = 1'b1;

	localparam logic [REG_W-1:0] THREAD_COUNT_RST = REG_W'(1);
	localparam logic [REG_W-1:0] TAG_COUNT_RST    = REG_W'(MAX_TAGS);

	// clamped round configuration seen by the election logic
	typedef struct packed {
		logic [REG_W-1:0] threads;
		logic [REG_W-1:0] tags;
	} cfg_t;

	// one election result
	typedef struct packed {
		logic              granted;
		logic [SLOT_W-1:0] slot;
	} res_t;

	// map 0 to 1 and anything above hi to hi
	function automatic logic [REG_W-1:0] clamp_cnt(input logic [REG_W-1:0] v,
	                                               input logic [REG_W-1:0] hi);
		logic [REG_W-1:0] r;
		r = v;
		if (v == '0)
			r = REG_W'(1);
		else if (v > hi)
			r = hi;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sexe_core.sv =====
// Election tables (arrival counters and per-thread ring positions) with their
// read-modify-write: combinational read, registered write. Depends on sexe_pkg.
`default_nettype none

module sexe_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic [sexe_pkg::TID_W-1:0] tid,
	input  wire sexe_pkg::cfg_t             cfg,
	output sexe_pkg::res_t                  res
);
	import sexe_pkg::*;

	logic [CNT_W-1:0]  arrival_q  [MAX_TAGS];
	logic [SLOT_W-1:0] position_q [MAX_THREADS];

	logic              tid_ok;
	logic              single;
	logic [SLOT_W-1:0] pos;
	logic [SLOT_W-1:0] slot;
	logic [CNT_W-1:0]  cnt;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [SLOT_W-1:0] pos_nxt;
	logic              upd;

	always_comb begin
		tid_ok = {1'b0, tid} < cfg.threads;
		single = cfg.threads == REG_W'(1);
		pos    = position_q[tid];
		// a position left beyond a lowered tag count restarts at slot 0
		slot   = ({1'b0, pos} >= cfg.tags) ? '0 : pos;
		cnt    = arrival_q[slot];
		if (cnt == '0)
			cnt_nxt = CNT_W'(1);
		else if ({1'b0, cnt} >= cfg.threads - REG_W'(1))
			cnt_nxt = '0;
		else
			cnt_nxt = cnt + CNT_W'(1);
		pos_nxt = ({1'b0, slot} + REG_W'(1) >= cfg.tags) ? '0 : slot + SLOT_W'(1);
		upd     = en && tid_ok && !single;

		if (!tid_ok) begin
			res.granted = 1'b0;
			res.slot    = '0;
		end else if (single) begin
			res.granted = 1'b1;
			res.slot    = pos;
		end else begin
			res.granted = cnt == '0;
			res.slot    = slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAGS; i++)
				arrival_q[i] <= '0;
			for (int i = 0; i < MAX_THREADS; i++)
				position_q[i] <= '0;
		end else if (upd) begin
			arrival_q[slot] <= cnt_nxt;
			position_q[tid] <= pos_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/single_executor_election_top.sv =====
// Single-executor election: input register, table update, result register.
// Throughput: one item per cycle while a full result register is not held by out_ready;
// each item's table read-modify-write is done in the input-register stage as it advances.
// Reset clears both tables and returns thread_count to 1, tag_count to 16.
// Depends on sexe_pkg and sexe_core.
`default_nettype none

module single_executor_election_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [sexe_pkg::TID_W-1:0]  thread_id,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             granted,
	output logic [sexe_pkg::SLOT_W-1:0]      slot_used,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [sexe_pkg::REG_W-1:0]  cfg_data
);
	import sexe_pkg::*;

	logic [REG_W-1:0] thread_count_q;
	logic [REG_W-1:0] tag_count_q;
	logic             v_s1;
	logic [TID_W-1:0] tid_s1;
	logic             adv_s1;
	cfg_t             cfg;
	res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thread_count_q <= THREAD_COUNT_RST;
			tag_count_q    <= TAG_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THREAD_COUNT: thread_count_q <= cfg_data;
				REG_TAG_COUNT:    tag_count_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_comb begin
		cfg.threads = clamp_cnt(thread_count_q, REG_W'(MAX_THREADS));
		cfg.tags    = clamp_cnt(tag_count_q, REG_W'(MAX_TAGS));
	end

	// stage 1 moves on when the result register is free or being drained
	assign adv_s1   = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_ready)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			tid_s1 <= thread_id;
	end

	sexe_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.tid    (tid_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv_s1)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			granted   <= res.granted;
			slot_used <= res.slot;
		end
	end

	// an accepted item always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted item not held in stage 1");

	// a thread id outside the round gives a refused result on slot 0
	a_bad_tid_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && ({1'b0, tid_s1} >= cfg.threads))
		|=> (out_valid && !granted && slot_used == '0))
		else $error("out-of-round thread produced a non-null result");

	// a single-thread round always grants
	a_single_grants: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cfg.threads == REG_W'(1) && tid_s1 == '0) |=> (out_valid && granted))
		else $error("single-thread round refused a request");

	// in a multi-thread round the counted slot lies inside the ring
	a_slot_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cfg.threads != REG_W'(1) && ({1'b0, tid_s1} < cfg.threads))
		|-> ({1'b0, res.slot} < cfg.tags))
		else $error("slot outside the tag ring");

endmodule

`default_nettype wire

// ===== tb/single_executor_election_top_tb.sv =====
// Self-checking testbench for single_executor_election_top: directed table, then phases
// of set and then random thread/tag settings, checked item by item against an in-bench election model.
// Depends on sexe_pkg and the RTL under rtl/core only.
`timescale 1ns / 100ps

module single_executor_election_top_tb;

	import sexe_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned ITEM_TARGET  = 1250;
	localparam int unsigned PHASE_ITEMS  = 110;
	localparam int unsigned SETTLE       = 4;     // cycles waited once all results are in
	localparam int unsigned HOLD_CYCLES  = 120;
	localparam int unsigned HOLD_TRIGGER = 333;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e        kind;
		logic             idx;
		logic [REG_W-1:0] value;    // thread id for items, write data for writes
		logic             typed;    // expectation given in the row
		logic             granted;
		logic [SLOT_W-1:0] slot;
	} row_t;

	localparam int unsigned N_ROWS = 24;
	localparam row_t DIRECTED [N_ROWS] = '{
		// single thread after reset; out-of-range id is refused
		'{ROW_ITEM, 1'b0,             5'd0,  1'b1, 1'b1, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd15, 1'b1, 1'b0, 4'd0},
		// thread count 0 acts as one
		'{ROW_CFG,  REG_THREAD_COUNT, 5'd0,  1'b0, 1'b0, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd0,  1'b1, 1'b1, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd1,  1'b1, 1'b0, 4'd0},
		// thread count saturates at 16, tag count 0 acts as one
		'{ROW_CFG,  REG_THREAD_COUNT, 5'd31, 1'b0, 1'b0, 4'd0},
		'{ROW_CFG,  REG_TAG_COUNT,    5'd0,  1'b0, 1'b0, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd15, 1'b1, 1'b1, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd0,  1'b1, 1'b0, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd7,  1'b0, 1'b0, 4'd0},
		// shrink the round: stale counter above the round gets cleared
		'{ROW_CFG,  REG_THREAD_COUNT, 5'd2,  1'b0, 1'b0, 4'd0},
		'{ROW_CFG,  REG_TAG_COUNT,    5'd31, 1'b0, 1'b0, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd0,  1'b0, 1'b0, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd1,  1'b0, 1'b0, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd0,  1'b0, 1'b0, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd1,  1'b0, 1'b0, 4'd0},
		// shrink the ring under a thread's position: falls back to slot 0
		'{ROW_CFG,  REG_TAG_COUNT,    5'd2,  1'b0, 1'b0, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd0,  1'b0, 1'b0, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd0,  1'b0, 1'b0, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd1,  1'b0, 1'b0, 4'd0},
		'{ROW_CFG,  REG_THREAD_COUNT, 5'd16, 1'b0, 1'b0, 4'd0},
		'{ROW_CFG,  REG_TAG_COUNT,    5'd16, 1'b0, 1'b0, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd15, 1'b0, 1'b0, 4'd0},
		'{ROW_ITEM, 1'b0,             5'd9,  1'b0, 1'b0, 4'd0}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [TID_W-1:0]  thread_id;
	logic              out_valid;
	logic              out_ready;
	logic              granted;
	logic [SLOT_W-1:0] slot_used;
	logic              cfg_we;
	logic              cfg_index;
	logic [REG_W-1:0]  cfg_data;

	// election model state
	logic [REG_W-1:0]  thread_cfg;
	logic [REG_W-1:0]  tag_cfg;
	logic [CNT_W-1:0]  arrivals [MAX_TAGS];
	logic [SLOT_W-1:0] ring_pos [MAX_THREADS];

	res_t              expected_votes [$];
	res_t              oldest_vote;
	int unsigned       mismatches;
	int unsigned       results_seen;
	int unsigned       cycles;
	int unsigned       hold_left;
	bit                hold_done;
	bit                no_idle;

	single_executor_election_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.thread_id (thread_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.granted   (granted),
		.slot_used (slot_used),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned eff_count(input logic [REG_W-1:0] v, input int unsigned hi);
		if (v == '0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// run one request through the model tables and return the vote
	function automatic res_t elect(input logic [TID_W-1:0] tid);
		int unsigned threads;
		int unsigned tags;
		int unsigned pos;
		int unsigned cnt;
		res_t        r;
		threads = eff_count(thread_cfg, MAX_THREADS);
		tags    = eff_count(tag_cfg, MAX_TAGS);
		r = '0;
		if (tid >= threads)
			return r;
		pos = ring_pos[tid];
		if (threads == 1) begin
			r.granted = 1'b1;
			r.slot    = pos[SLOT_W-1:0];
			return r;
		end
		if (pos >= tags)
			pos = 0;
		cnt = arrivals[pos];
		if (cnt == 0) begin
			arrivals[pos] = CNT_W'(1);
			r.granted = 1'b1;
		end else begin
			arrivals[pos] = (cnt >= threads - 1) ? '0 : CNT_W'(cnt + 1);
		end
		ring_pos[tid] = (pos + 1 >= tags) ? '0 : SLOT_W'(pos + 1);
		r.slot = pos[SLOT_W-1:0];
		return r;
	endfunction

	task automatic write_reg(input logic idx, input logic [REG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == REG_THREAD_COUNT)
			thread_cfg = value;
		else
			tag_cfg = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// drop valid and wait for every outstanding result, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_votes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic offer(input logic [TID_W-1:0] tid, input bit typed, input res_t given);
		res_t v;
		while (!no_idle && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		thread_id <= tid;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		v = elect(tid);
		expected_votes.push_back(typed ? given : v);
	endtask

	task automatic note_mismatch(input string what, input res_t exp_v, input res_t act_v);
		if (mismatches < 10)
			$display("tb: mismatch (%s) at %0t: expected granted=%0d slot=%0d, got granted=%0d slot=%0d",
			         what, $realtime, exp_v.granted, exp_v.slot, act_v.granted, act_v.slot);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_votes.size() == 0) begin
				note_mismatch("unexpected item", '0, {granted, slot_used});
			end else begin
				oldest_vote = expected_votes.pop_front();
				if (oldest_vote.granted !== granted || oldest_vote.slot !== slot_used)
					note_mismatch("field", oldest_vote, {granted, slot_used});
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back the block up
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && results_seen >= HOLD_TRIGGER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_idle || ($urandom_range(99) >= 13);
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [REG_W-1:0] phase_tc [8] = '{5'd1, 5'd16, 5'd16, 5'd2, 5'd31, 5'd0, 5'd2, 5'd5};
		logic [REG_W-1:0] phase_tg [8] = '{5'd16, 5'd16, 5'd1, 5'd1, 5'd0, 5'd31, 5'd16, 5'd7};
		int unsigned       valid_sent;
		int unsigned       phase_sent;
		int unsigned       phase;
		int unsigned       threads;
		logic [TID_W-1:0]  tid;
		logic [REG_W-1:0]  tc;
		logic [REG_W-1:0]  tg;

		arst_n     = 1'b0;
		in_valid  <= 1'b0;
		thread_id <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= 1'b0;
		cfg_data  <= '0;
		mismatches   = 0;
		results_seen = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		no_idle      = 1'b0;
		thread_cfg   = THREAD_COUNT_RST;
		tag_cfg      = TAG_COUNT_RST;
		foreach (arrivals[i])
			arrivals[i] = '0;
		foreach (ring_pos[i])
			ring_pos[i] = '0;
		valid_sent = 0;
		phase      = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_CFG) begin
				drain();
				write_reg(DIRECTED[r].idx, DIRECTED[r].value);
			end else begin
				offer(DIRECTED[r].value[TID_W-1:0], DIRECTED[r].typed,
				      {DIRECTED[r].granted, DIRECTED[r].slot});
			end
		end

		while (valid_sent < ITEM_TARGET) begin
			if (phase < 8) begin
				tc = phase_tc[phase];
				tg = phase_tg[phase];
			end else begin
				tc = REG_W'($urandom_range(31));
				tg = REG_W'($urandom_range(31));
			end
			drain();
			write_reg(REG_THREAD_COUNT, tc);
			write_reg(REG_TAG_COUNT, tg);
			threads = eff_count(tc, MAX_THREADS);
			no_idle = (phase == 2);
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS && valid_sent < ITEM_TARGET) begin
				// hold the sender until the block is empty, mid-phase
				if (phase == 4 && phase_sent == PHASE_ITEMS / 2)
					drain();
				if ($urandom_range(99) < 85)
					tid = TID_W'($urandom_range(threads - 1));
				else
					tid = TID_W'($urandom_range(15));
				offer(tid, 1'b0, '0);
				valid_sent++;
				if (tid < threads)
					phase_sent++;
			end
			phase++;
		end
		no_idle = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_votes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/sexe_pkg.sv
rtl/core/sexe_core.sv
rtl/core/single_executor_election_top.sv
tb/single_executor_election_top_tb.sv
